// ===== hw/rtl/lseg_pkg.sv =====
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types, codes and constants of the LED strip effect generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_BREATH  = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_MARQUEE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EFFECT_MODE = 3'd0,
    REG_BRIGHTNESS  = 3'd1,
    REG_COLOR_RED   = 3'd2,
    REG_COLOR_GREEN = 3'd3,
    REG_COLOR_BLUE  = 3'd4
  } cfg_reg_t;

  localparam logic [6:0]  BREATH_MAX   = 7'd80;
  localparam logic [6:0]  BREATH_STEP  = 7'd5;
  localparam logic [7:0]  RAINBOW_STEP = 8'd5;
  localparam logic [6:0]  PERCENT_MAX  = 7'd100;
  localparam logic [7:0]  WHEEL_SEG1   = 8'd85;
  localparam logic [7:0]  WHEEL_SEG2   = 8'd170;
  localparam logic [7:0]  CHAN_MAX     = 8'd255;

  // Constant division: x/80 = (x>>4)/5, and x/100; reciprocals scaled by 2^16
  localparam int          DIV_COARSE_SHIFT = 4;
  localparam logic [6:0]  DIV_FINE         = 7'd5;
  localparam logic [13:0] RECIP_DIV5       = 14'd13107;
  localparam logic [13:0] RECIP_DIV100     = 14'd655;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [6:0] breath_level;
    logic       breath_rising;
    logic [7:0] rainbow_offset;
    logic [5:0] marquee_position;
  } anim_t;

  typedef struct packed {
    logic       start;
    logic [7:0] x;
    logic [6:0] m;
    logic       div80;
  } scl_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q;
  } scl_rsp_t;

  function automatic rgb_t wheel(input logic [7:0] p);
    rgb_t       c;
    logic [7:0] q;
    c = '0;
    if (p < WHEEL_SEG1) begin
      q   = p;
      c.r = 8'({1'b0, q} + {q, 1'b0});
      c.g = CHAN_MAX - c.r;
    end else if (p < WHEEL_SEG2) begin
      q   = p - WHEEL_SEG1;
      c.b = 8'({1'b0, q} + {q, 1'b0});
      c.r = CHAN_MAX - c.b;
    end else begin
      q   = p - WHEEL_SEG2;
      c.g = 8'({1'b0, q} + {q, 1'b0});
      c.b = CHAN_MAX - c.g;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/lseg_ifs.sv =====
// ----------------------------------------------------------------------------
// lseg channel interfaces
// Frame request, pixel result and configuration write channels.
// ----------------------------------------------------------------------------
interface lseg_frame_if;
  logic valid;
  logic ready;
  logic advance;
  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface lseg_pixel_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input last_pixel, output ready);
endinterface

interface lseg_cfg_if;
  import lseg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lseg_scale_unit.sv =====
// ----------------------------------------------------------------------------
// lseg_scale_unit
// Shared scaler: q = x * m / 80 or x * m / 100; product, coarse quotient and corrected quotient are registered in turn.
// ----------------------------------------------------------------------------
module lseg_scale_unit (
  input  logic             clk,
  input  logic             rst,
  input  lseg_pkg::scl_req_t req,
  output lseg_pkg::scl_rsp_t rsp
);
  import lseg_pkg::*;

  logic        v1;
  logic        v2;
  logic [14:0] prod;
  logic        d80_1;
  logic [14:0] dvd;
  logic [7:0]  q0;
  logic        d80_2;

  logic [14:0] dvd_sel;
  logic [13:0] recip;
  logic [28:0] approx;
  logic [6:0]  divisor;
  logic [14:0] back;
  logic [14:0] rem;

  // Stage 2: coarse quotient by reciprocal, never above the true quotient
  always_comb begin
    dvd_sel = d80_1 ? (prod >> DIV_COARSE_SHIFT) : prod;
    recip   = d80_1 ? RECIP_DIV5 : RECIP_DIV100;
    approx  = 29'(dvd_sel) * 29'(recip);
  end

  // Stage 3: one correction step
  always_comb begin
    divisor = d80_2 ? DIV_FINE : PERCENT_MAX;
    back    = 15'(q0) * 15'(divisor);
    rem     = dvd - back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      v1       <= req.start;
      v2       <= v1;
      rsp.done <= v2;
    end
    prod  <= 15'(req.x) * 15'(req.m);
    d80_1 <= req.div80;
    q0    <= approx[23:16];
    dvd   <= dvd_sel;
    d80_2 <= d80_1;
    rsp.q <= (rem >= 15'(divisor)) ? q0 + 8'd1 : q0;
  end

endmodule

// ===== hw/rtl/lseg_anim.sv =====
// ----------------------------------------------------------------------------
// lseg_anim
// Animation state: breath ramp, rainbow offset and marquee position.
// ----------------------------------------------------------------------------
module lseg_anim #(
  parameter int LED_USED = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode_wr,
  input  logic            step,
  input  lseg_pkg::mode_t mode,
  output lseg_pkg::anim_t anim
);
  import lseg_pkg::*;

  anim_t      anim_next;
  logic [6:0] lvl;
  logic [6:0] pos_inc;

  always_comb begin
    anim_next = anim;
    lvl       = anim.breath_level;
    pos_inc   = {1'b0, anim.marquee_position} + 7'd1;
    if (step) begin
      case (mode)
        MODE_BREATH: begin
          if (anim.breath_rising) begin
            lvl = anim.breath_level + BREATH_STEP;
          end else if (anim.breath_level >= BREATH_STEP) begin
            lvl = anim.breath_level - BREATH_STEP;
          end else begin
            lvl = '0;
          end
          anim_next.breath_level = lvl;
          if (lvl >= BREATH_MAX) begin
            anim_next.breath_level  = BREATH_MAX;
            anim_next.breath_rising = 1'b0;
          end
          if (lvl == '0) begin
            anim_next.breath_rising = 1'b1;
          end
        end
        MODE_RAINBOW: anim_next.rainbow_offset = anim.rainbow_offset + RAINBOW_STEP;
        MODE_MARQUEE: begin
          anim_next.marquee_position = (pos_inc >= 7'(LED_USED)) ? '0 : pos_inc[5:0];
        end
        default: ;
      endcase
    end
    if (mode_wr) begin
      anim_next.breath_level  = '0;
      anim_next.breath_rising = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anim.breath_level     <= '0;
      anim.breath_rising    <= 1'b1;
      anim.rainbow_offset   <= '0;
      anim.marquee_position <= '0;
    end else begin
      anim <= anim_next;
    end
  end

endmodule

// ===== hw/rtl/led_strip_effect_generator.sv =====
// ----------------------------------------------------------------------------
// led_strip_effect_generator
// Renders one frame of LED colors per frame request through a shared scaler.
// ----------------------------------------------------------------------------
// Usage:
//   frame_req  - one request per frame; advance=1 renders, then steps the
//                animation; advance=0 renders only. Taken only when idle.
//   pixel_out  - LED_COUNT results per request, index order, last_pixel on
//                the final LED. A registered output stage holds each pixel.
//   cfg        - register writes (mode, brightness, color); always ready,
//                write only while no frame is in flight.
// Scaling: each color channel passes once through the three-stage scaler;
//   breath needs two passes per channel. The single scaler serves every pass,
//   and a pass is issued only after the previous one has returned.
// Stall: while pixel_out is held off the sequencer waits with the next pixel
//   computed; nothing is dropped.
// Reset (rst, synchronous): mode off, brightness 100, color green, breath
//   ramp at 0 rising, rainbow offset and marquee position 0.
// ----------------------------------------------------------------------------
module led_strip_effect_generator #(
  parameter int LED_COUNT = 16,
  parameter int LED_USED  = 16
) (
  input  logic         clk,
  input  logic         rst,
  lseg_frame_if.sink   frame_req,
  lseg_pixel_if.source pixel_out,
  lseg_cfg_if.sink     cfg
);
  import lseg_pkg::*;

  localparam int SPREAD_Q = 256 / LED_USED;
  localparam int SPREAD_R = 256 % LED_USED;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PIX   = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_OUT   = 6'b010000,
    S_ADV   = 6'b100000
  } state_t;

  // Configuration registers
  mode_t      mode;
  logic [6:0] bright;
  rgb_t       col;

  // Sequencer registers
  state_t     state;
  logic [5:0] idx;
  logic       adv_lat;
  logic [1:0] chan;
  logic       breath_pass;
  rgb_t       src;
  rgb_t       res;
  logic [7:0] spread_q;
  logic [6:0] spread_r;

  anim_t      anim;
  scl_req_t   scl_req;
  scl_rsp_t   scl_rsp;

  logic       mode_wr;
  logic       anim_step;
  logic [6:0] bright_eff;
  logic       in_used;
  rgb_t       pix_src;
  logic [7:0] src_sel;
  logic [6:0] spread_sum;
  logic       out_free;
  logic       last_idx;

  // ---- configuration port --------------------------------------------------
  assign cfg.ready = 1'b1;
  assign mode_wr   = cfg.valid && (cfg_reg_t'(cfg.index) == REG_EFFECT_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_OFF;
      bright <= PERCENT_MAX;
      col.r  <= 8'd0;
      col.g  <= CHAN_MAX;
      col.b  <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_EFFECT_MODE: mode   <= mode_t'(cfg.data[1:0]);
        REG_BRIGHTNESS:  bright <= cfg.data[6:0];
        REG_COLOR_RED:   col.r  <= cfg.data;
        REG_COLOR_GREEN: col.g  <= cfg.data;
        REG_COLOR_BLUE:  col.b  <= cfg.data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---- animation state -----------------------------------------------------
  assign anim_step = (state == S_ADV) && adv_lat;

  lseg_anim #(
    .LED_USED (LED_USED)
  ) u_anim (
    .clk     (clk),
    .rst     (rst),
    .mode_wr (mode_wr),
    .step    (anim_step),
    .mode    (mode),
    .anim    (anim)
  );

  // ---- pixel source color --------------------------------------------------
  // Brightness above one hundred acts as one hundred.
  assign bright_eff = (bright > PERCENT_MAX) ? PERCENT_MAX : bright;
  assign in_used    = {1'b0, idx} < 7'(LED_USED);

  always_comb begin
    pix_src = '0;
    case (mode)
      MODE_BREATH:  pix_src = col;
      MODE_RAINBOW: pix_src = wheel(anim.rainbow_offset + spread_q);
      MODE_MARQUEE: if (idx == anim.marquee_position) pix_src = col;
      default:      pix_src = '0;
    endcase
    // LEDs past the used count stay black
    if (!in_used) pix_src = '0;
  end

  // ---- shared scaler -------------------------------------------------------
  always_comb begin
    case (chan)
      2'd0:    src_sel = src.r;
      2'd1:    src_sel = src.g;
      default: src_sel = src.b;
    endcase
    scl_req.start = (state == S_ISSUE);
    scl_req.x     = src_sel;
    // Breath first pass scales by the ramp (/80), then every pass by brightness
    scl_req.m     = breath_pass ? anim.breath_level : bright_eff;
    scl_req.div80 = breath_pass;
  end

  lseg_scale_unit u_scale (
    .clk (clk),
    .rst (rst),
    .req (scl_req),
    .rsp (scl_rsp)
  );

  // ---- sequencer -----------------------------------------------------------
  assign frame_req.ready = (state == S_IDLE);
  assign out_free        = !pixel_out.valid || pixel_out.ready;
  assign last_idx        = (idx == 6'(LED_COUNT - 1));
  assign spread_sum      = spread_r + 7'(SPREAD_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pixel_out.valid <= 1'b0;
    end else begin
      // Drain the output stage when taken; a load below overrides
      if (pixel_out.valid && pixel_out.ready) pixel_out.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (frame_req.valid) state <= S_PIX;
        end
        S_PIX:   state <= S_ISSUE;
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (scl_rsp.done) begin
            if (breath_pass || chan != 2'd2) state <= S_ISSUE;
            else state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            pixel_out.valid <= 1'b1;
            state           <= last_idx ? S_ADV : S_PIX;
          end
        end
        S_ADV:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        adv_lat  <= frame_req.advance;
        idx      <= '0;
        spread_q <= '0;
        spread_r <= '0;
      end
      S_PIX: begin
        src         <= pix_src;
        chan        <= 2'd0;
        breath_pass <= (mode == MODE_BREATH);
      end
      S_WAIT: begin
        if (scl_rsp.done) begin
          if (breath_pass) begin
            // Hold the ramped value for the brightness pass
            case (chan)
              2'd0:    src.r <= scl_rsp.q;
              2'd1:    src.g <= scl_rsp.q;
              default: src.b <= scl_rsp.q;
            endcase
            breath_pass <= 1'b0;
          end else begin
            case (chan)
              2'd0:    res.r <= scl_rsp.q;
              2'd1:    res.g <= scl_rsp.q;
              default: res.b <= scl_rsp.q;
            endcase
            chan        <= chan + 2'd1;
            breath_pass <= (mode == MODE_BREATH);
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          pixel_out.pixel_index <= idx;
          pixel_out.red         <= res.r;
          pixel_out.green       <= res.g;
          pixel_out.blue        <= res.b;
          pixel_out.last_pixel  <= last_idx;
          idx                   <= idx + 6'd1;
          // Advance the rainbow spread i*256/LED_USED without a divider
          if (spread_sum >= 7'(LED_USED)) begin
            spread_r <= spread_sum - 7'(LED_USED);
            spread_q <= spread_q + 8'(SPREAD_Q) + 8'd1;
          end else begin
            spread_r <= spread_sum;
            spread_q <= spread_q + 8'(SPREAD_Q);
          end
        end
      end
      default: ;
    endcase
  end

  // ---- assertions ----------------------------------------------------------
  a_scale_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    scl_rsp.done |-> state == S_WAIT)
    else $error("scaler result arrived outside the wait state");

  a_breath_bounded: assert property (@(posedge clk) disable iff (rst)
    anim.breath_level <= BREATH_MAX)
    else $error("breath ramp above its maximum");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid && pixel_out.last_pixel |-> pixel_out.pixel_index == 6'(LED_COUNT - 1))
    else $error("last pixel flag on wrong index");

  a_idle_no_pixel_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV) |=> !scl_rsp.done && frame_req.ready)
    else $error("scaler busy or not ready after frame end");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED strip effect generator. Frame requests go
// in with random gaps, pixel results are drained with random back-pressure,
// and every pixel is checked against a behavioral model of the four effects.
// ----------------------------------------------------------------------------
module tb_top;
  import lseg_pkg::*;

  localparam int LED_COUNT       = 16;
  localparam int LED_USED        = 16;
  localparam int RANDOM_FRAMES   = 105;
  localparam int CALM_FRAMES     = 20;     // last random frames run with no idling
  localparam int SETTLE_CYCLES   = 30;     // block goes idle right after its last pixel
  localparam int END_CYCLES      = 500;    // about one breath frame
  localparam int PRESSURE_CYCLES = 1500;   // long output hold-off
  localparam int WATCHDOG_LIMIT  = 10000;  // cycles with no handshake at all
  localparam int MAX_REPORTS     = 10;

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [5:0] pos;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       is_last;
  } pixel_t;

  // --------------------------------------------------------------------------
  // Expected-pixel store plus a model of the effect state
  // --------------------------------------------------------------------------
  class led_frame_scoreboard #(int NUM_LEDS = 16, int NUM_USED = 16);
    mode_t       mode;
    logic [6:0]  bright;
    logic [7:0]  base_r;
    logic [7:0]  base_g;
    logic [7:0]  base_b;
    int unsigned ramp;
    bit          ramp_up;
    int unsigned hue_offset;
    int unsigned spot;
    pixel_t      pending_px[$];
    int unsigned mismatches;
    int unsigned pixels_seen;
    int unsigned writes_seen;
    int unsigned mode_frames[4];

    function new();
      mode       = MODE_OFF;
      bright     = PERCENT_MAX;
      base_r     = 8'd0;
      base_g     = CHAN_MAX;
      base_b     = 8'd0;
      ramp       = 0;
      ramp_up    = 1'b1;
      hue_offset = 0;
      spot       = 0;
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes_seen++;
      case (idx)
        REG_EFFECT_MODE: begin
          // any mode write restarts the breath ramp; rainbow and marquee keep going
          mode    = mode_t'(data[1:0]);
          ramp    = 0;
          ramp_up = 1'b1;
        end
        REG_BRIGHTNESS:  bright = data[6:0];
        REG_COLOR_RED:   base_r = data;
        REG_COLOR_GREEN: base_g = data;
        REG_COLOR_BLUE:  base_b = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] dim(int unsigned c);
      int unsigned pct;
      pct = (bright > PERCENT_MAX) ? PERCENT_MAX : bright;
      return 8'((c & CHAN_MAX) * pct / PERCENT_MAX);
    endfunction

    function pixel_t hue_color(int unsigned p);
      pixel_t      c;
      int unsigned q;
      c = '0;
      if (p < WHEEL_SEG1) begin
        c.r = 8'(3 * p);
        c.g = 8'(CHAN_MAX - 3 * p);
      end else if (p < WHEEL_SEG2) begin
        q   = p - WHEEL_SEG1;
        c.r = 8'(CHAN_MAX - 3 * q);
        c.b = 8'(3 * q);
      end else begin
        q   = p - WHEEL_SEG2;
        c.g = 8'(3 * q);
        c.b = 8'(CHAN_MAX - 3 * q);
      end
      return c;
    endfunction

    // Render one frame request into the store, then step the animation if advance is set
    function void note_frame(logic adv);
      pixel_t px;
      pixel_t w;
      mode_frames[mode]++;
      for (int i = 0; i < NUM_LEDS; i++) begin
        px         = '0;
        px.pos     = 6'(i);
        px.is_last = (i == NUM_LEDS - 1);
        if (i < NUM_USED) begin
          case (mode)
            MODE_BREATH: begin
              px.r = dim(base_r * ramp / BREATH_MAX);
              px.g = dim(base_g * ramp / BREATH_MAX);
              px.b = dim(base_b * ramp / BREATH_MAX);
            end
            MODE_RAINBOW: begin
              w    = hue_color((hue_offset + i * 256 / NUM_USED) & CHAN_MAX);
              px.r = dim(w.r);
              px.g = dim(w.g);
              px.b = dim(w.b);
            end
            MODE_MARQUEE: begin
              if (i == spot) begin
                px.r = dim(base_r);
                px.g = dim(base_g);
                px.b = dim(base_b);
              end
            end
            default: ;
          endcase
        end
        pending_px.push_back(px);
      end
      if (adv) begin
        case (mode)
          MODE_BREATH: begin
            if (ramp_up) ramp = ramp + BREATH_STEP;
            else         ramp = (ramp >= BREATH_STEP) ? ramp - BREATH_STEP : 0;
            if (ramp >= BREATH_MAX) begin
              ramp    = BREATH_MAX;
              ramp_up = 1'b0;
            end
            if (ramp == 0) ramp_up = 1'b1;
          end
          MODE_RAINBOW: hue_offset = (hue_offset + RAINBOW_STEP) & CHAN_MAX;
          MODE_MARQUEE: spot = (spot + 1) % NUM_USED;
          default: ;
        endcase
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels_seen++;
      if (pending_px.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected pixel idx %0d rgb %02h %02h %02h last %0b",
                   $realtime, got.pos, got.r, got.g, got.b, got.is_last);
        mismatches++;
        return;
      end
      want = pending_px.pop_front();
      if (got.pos !== want.pos || got.r !== want.r || got.g !== want.g ||
          got.b !== want.b || got.is_last !== want.is_last) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: pixel mismatch, want idx %0d rgb %02h %02h %02h last %0b, got idx %0d rgb %02h %02h %02h last %0b",
                   $realtime, want.pos, want.r, want.g, want.b, want.is_last,
                   got.pos, got.r, got.g, got.b, got.is_last);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  lseg_frame_if frame_ch ();
  lseg_pixel_if pix_ch ();
  lseg_cfg_if   cfg_ch ();

  led_strip_effect_generator #(
    .LED_COUNT (LED_COUNT),
    .LED_USED  (LED_USED)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .frame_req (frame_ch),
    .pixel_out (pix_ch),
    .cfg       (cfg_ch)
  );

  led_frame_scoreboard #(LED_COUNT, LED_USED) sb;

  bit          calm        = 1'b0;  // no idling on either side
  bit          hold_pixels = 1'b0;  // ask the receiver for one long hold-off
  int unsigned long_holds  = 0;
  int unsigned idle_count  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake on the edge where it completes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.note_write(cfg_ch.index, cfg_ch.data);
      if (pix_ch.valid && pix_ch.ready)
        sb.check_pixel(pixel_t'{pix_ch.pixel_index, pix_ch.red, pix_ch.green,
                                pix_ch.blue, pix_ch.last_pixel});
      if (frame_ch.valid && frame_ch.ready)
        sb.note_frame(frame_ch.advance);
    end
  end

  // Watchdog: end the run if no channel moves for too long
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
        (frame_ch.valid && frame_ch.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles, %0d pixels outstanding",
               $realtime, WATCHDOG_LIMIT, sb.pending_px.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Pixel receiver: random stalls, long ready runs, one long hold-off on demand
  // --------------------------------------------------------------------------
  initial begin
    pix_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pixels) begin
        // hold the output so the block backs up and stops taking requests
        pix_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_pixels = 1'b0;
        long_holds++;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        pix_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      if (calm)                          @(posedge clk);
      else if ($urandom_range(0, 9) == 0) repeat (400) @(posedge clk);
      else                               repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one frame request and hold it until taken; leave valid high so a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_frame(input logic adv);
    frame_ch.valid   <= 1'b1;
    frame_ch.advance <= adv;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_frames(input int n, input logic adv);
    repeat (n) begin
      send_frame(adv);
      sender_gap();
    end
  endtask

  // Register write; valid stays high, the caller drops it after the group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Stop offering frames, wait for every expected pixel, let the block settle
  task automatic quiesce();
    frame_ch.valid <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return CHAN_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_frames;
    int unsigned phase;
    int unsigned n;

    sb = new();
    frame_ch.valid   <= 1'b0;
    frame_ch.advance <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    rst              <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: mode off renders black, with and without advance
    send_frames(1, 1'b0);
    send_frames(1, 1'b1);

    // Marquee in the reset color; upper data bits of the mode write are dropped
    quiesce();
    write_reg(REG_EFFECT_MODE, {6'h3F, MODE_MARQUEE});
    quiesce();
    send_frames(2, 1'b1);

    // Brightness above one hundred clamps to full scale; zero gives black
    quiesce();
    write_reg(REG_COLOR_RED, CHAN_MAX);
    write_reg(REG_COLOR_GREEN, CHAN_MAX);
    write_reg(REG_COLOR_BLUE, CHAN_MAX);
    write_reg(REG_BRIGHTNESS, 8'hFF);
    quiesce();
    send_frames(1, 1'b1);
    quiesce();
    write_reg(REG_BRIGHTNESS, 8'd0);
    quiesce();
    send_frames(1, 1'b1);
    quiesce();
    write_reg(REG_BRIGHTNESS, 8'd101);
    quiesce();
    send_frames(1, 1'b1);

    // Writes to undecoded indexes change nothing
    quiesce();
    write_reg(REG_UNUSED_FIRST, 8'hAA);
    write_reg(3'(REG_UNUSED_FIRST + 3'd1), 8'h55);
    write_reg(REG_UNUSED_LAST, 8'hFF);
    quiesce();
    send_frames(1, 1'b1);

    // Breath ramp, then a repeated mode write restarts it
    quiesce();
    write_reg(REG_COLOR_RED, CHAN_MAX);
    write_reg(REG_COLOR_GREEN, 8'h80);
    write_reg(REG_COLOR_BLUE, 8'h01);
    write_reg(REG_BRIGHTNESS, 8'(PERCENT_MAX));
    write_reg(REG_EFFECT_MODE, 8'(MODE_BREATH));
    quiesce();
    send_frames(3, 1'b1);
    quiesce();
    write_reg(REG_EFFECT_MODE, 8'(MODE_BREATH));
    quiesce();
    send_frames(2, 1'b1);

    // Rainbow, render-only frame, dimmed frame
    quiesce();
    write_reg(REG_EFFECT_MODE, 8'(MODE_RAINBOW));
    quiesce();
    send_frames(3, 1'b1);
    send_frames(1, 1'b0);
    quiesce();
    write_reg(REG_BRIGHTNESS, 8'd50);
    quiesce();
    send_frames(1, 1'b1);

    // Marquee position and rainbow offset survive mode writes
    quiesce();
    write_reg(REG_EFFECT_MODE, 8'(MODE_MARQUEE));
    quiesce();
    send_frames(1, 1'b1);
    quiesce();
    write_reg(REG_EFFECT_MODE, 8'(MODE_RAINBOW));
    quiesce();
    send_frames(1, 1'b1);

    // Random phases: a fresh register setting, then a run of frame requests
    rand_frames = 0;
    phase       = 0;
    while (rand_frames < RANDOM_FRAMES) begin
      quiesce();
      if (phase == 0) begin
        // long breath run so the ramp bounces off both ends
        write_reg(REG_COLOR_RED, pick_color());
        write_reg(REG_COLOR_GREEN, pick_color());
        write_reg(REG_COLOR_BLUE, pick_color());
        write_reg(REG_BRIGHTNESS, 8'(PERCENT_MAX));
        write_reg(REG_EFFECT_MODE, 8'(MODE_BREATH));
        n = 36;
      end else begin
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_EFFECT_MODE, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: write_reg(REG_BRIGHTNESS, 8'd0);
          1: write_reg(REG_BRIGHTNESS, 8'(PERCENT_MAX));
          2: write_reg(REG_BRIGHTNESS, 8'($urandom_range(0, 255)));
          default: ;
        endcase
        if ($urandom_range(0, 1) == 0) write_reg(REG_COLOR_RED, pick_color());
        if ($urandom_range(0, 1) == 0) write_reg(REG_COLOR_GREEN, pick_color());
        if ($urandom_range(0, 1) == 0) write_reg(REG_COLOR_BLUE, pick_color());
        if ($urandom_range(0, 5) == 0)
          write_reg(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                    8'($urandom_range(0, 255)));
        n = $urandom_range(4, 24);
      end
      cfg_ch.valid <= 1'b0;
      // one phase keeps offering requests while the output is held off
      if (phase == 2) hold_pixels = 1'b1;
      repeat (n) begin
        send_frame((phase == 0) ? 1'b1 : 1'($urandom_range(0, 4) != 0));
        rand_frames++;
        if (rand_frames + CALM_FRAMES >= RANDOM_FRAMES) calm = 1'b1;
        if (phase != 2) sender_gap();
      end
      phase++;
    end

    // Drain and allow a frame's worth of cycles for anything stray
    quiesce();
    repeat (END_CYCLES) @(posedge clk);

    $display("Ran %0d pixels over off/breath/rainbow/marquee frames %0d/%0d/%0d/%0d,",
             sb.pixels_seen, sb.mode_frames[MODE_OFF], sb.mode_frames[MODE_BREATH],
             sb.mode_frames[MODE_RAINBOW], sb.mode_frames[MODE_MARQUEE]);
    $display("with %0d register writes, %0d long output hold-offs, %0d mismatches.",
             sb.writes_seen, long_holds, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_px.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== led_strip_effect_generator.f =====
hw/rtl/lseg_pkg.sv
hw/rtl/lseg_ifs.sv
hw/rtl/lseg_scale_unit.sv
hw/rtl/lseg_anim.sv
hw/rtl/led_strip_effect_generator.sv
tb/tb_top.sv
